FILE: hdl/servo_position_p_controller_core_macros.svh
// assertion helpers, clocked on clk and disabled in reset
`ifndef SERVO_POSITION_P_CONTROLLER_CORE_MACROS_SVH
`define SERVO_POSITION_P_CONTROLLER_CORE_MACROS_SVH

`ifndef SYNTH

`define SPC_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

`define SPC_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`else

`define SPC_ASSERT_ALWAYS(label, expr)

`define SPC_ASSERT_IMPLY(label, ante, cons)

`endif

`endif

FILE: hdl/spc_pkg.sv
package spc_pkg;

  localparam int unsigned KP_W    = 20;
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned TA_W    = 17;
  localparam int unsigned VEL_W   = 12;
  localparam int unsigned PULSE_W = 11;
  localparam int unsigned MUL_A_W = 21;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned MUL_P_W = 38;
  localparam int unsigned VEL_SH  = 14;

  localparam logic [KP_W-1:0]           KP_RESET   = 20'd65536;
  localparam logic [ANGLE_W-1:0]        ANGLE_MAX  = 16'd46080;
  localparam logic signed [VEL_W-1:0]   VEL_MAX    = 12'sd1024;
  localparam logic signed [VEL_W-1:0]   VEL_MIN    = -12'sd1024;
  localparam logic [PULSE_W-1:0]        PULSE_MID  = 11'd1500;
  localparam logic signed [MUL_B_W-1:0] PULSE_SPAN = 17'sd400;
  localparam logic signed [MUL_B_W-1:0] STEP_MUL   = 17'sd5;

  localparam logic OP_SET  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAIN,
    ST_VEL,
    ST_PULSE,
    ST_STEP,
    ST_EST
  } state_t;

  typedef enum logic [1:0] {
    SEL_GAIN,
    SEL_PULSE,
    SEL_STEP
  } mul_sel_t;

  typedef struct packed {
    logic     in_ready;
    logic     set_tgt;
    logic     load_vel;
    logic     load_pulse;
    logic     load_out;
    mul_sel_t mul_sel;
  } ctl_t;

endpackage

FILE: hdl/spc_ifs.sv
interface spc_cmd_if import spc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   operation;
  logic signed [TA_W-1:0] goal_angle;

  modport source (output valid, output operation, output goal_angle, input ready);
  modport sink (input valid, input operation, input goal_angle, output ready);
endinterface

interface spc_res_if import spc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [PULSE_W-1:0]      pulse_width;
  logic signed [VEL_W-1:0] velocity;
  logic [ANGLE_W-1:0]      estimated_angle;

  modport source (output valid, output pulse_width, output velocity,
                  output estimated_angle, input ready);
  modport sink (input valid, input pulse_width, input velocity,
                input estimated_angle, output ready);
endinterface

interface spc_cfg_if import spc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [KP_W-1:0] kp;

  modport source (output valid, output kp, input ready);
  modport sink (input valid, input kp, output ready);
endinterface

FILE: hdl/spc_mul.sv
module spc_mul import spc_pkg::*; (
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

FILE: hdl/spc_seq.sv
module spc_seq import spc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  logic cmd_op,
  input  logic out_busy,
  output ctl_t ctl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    ctl.in_ready   = 1'b0;
    ctl.set_tgt    = 1'b0;
    ctl.load_vel   = 1'b0;
    ctl.load_pulse = 1'b0;
    ctl.load_out   = 1'b0;
    ctl.mul_sel    = SEL_GAIN;
    case (state)
      ST_IDLE: begin
        ctl.in_ready = 1'b1;
        if (cmd_valid) begin
          if (cmd_op == OP_TICK) begin
            state_next = ST_GAIN;
          end else begin
            ctl.set_tgt = 1'b1;
          end
        end
      end
      ST_GAIN: begin
        ctl.mul_sel = SEL_GAIN;
        state_next  = ST_VEL;
      end
      ST_VEL: begin
        ctl.load_vel = 1'b1;
        state_next   = ST_PULSE;
      end
      ST_PULSE: begin
        ctl.mul_sel = SEL_PULSE;
        state_next  = ST_STEP;
      end
      ST_STEP: begin
        ctl.load_pulse = 1'b1;
        ctl.mul_sel    = SEL_STEP;
        state_next     = ST_EST;
      end
      ST_EST: begin
        ctl.mul_sel = SEL_STEP;
        if (!out_busy) begin
          ctl.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/servo_position_p_controller_core.sv
// Proportional position controller for a continuous-rotation servo. A set-target word
// (operation 0) is taken and stores the angle clamped to 0..46080 (1/256 deg); it gives no
// result. A control tick (operation 1) stalls in its last state while the result register is
// full. One shared 21x17 multiplier is used in turn for kp*error, velocity*400 and
// velocity*5, each product registered before use. The result word waits in an output
// register, and a following set-target word is taken while it waits. The gain register kp
// resets to 65536 and is written through the cfg channel.
`include "servo_position_p_controller_core_macros.svh"

module servo_position_p_controller_core import spc_pkg::*; (
  input logic     clk,
  input logic     rst,
  spc_cmd_if.sink cmd,
  spc_cfg_if.sink cfg,
  spc_res_if.source res
);

  ctl_t ctl;
  logic out_busy;

  logic [KP_W-1:0]         kp;
  logic [ANGLE_W-1:0]      tgt_pos;
  logic [ANGLE_W-1:0]      est_pos;
  logic signed [VEL_W-1:0] vel;
  logic [PULSE_W-1:0]      pulse;

  logic                    res_valid;
  logic [PULSE_W-1:0]      res_pulse;
  logic signed [VEL_W-1:0] res_vel;
  logic [ANGLE_W-1:0]      res_est;

  logic signed [TA_W-1:0]    err;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  logic signed [MUL_P_W-VEL_SH-1:0] vel_raw;
  logic signed [VEL_W-1:0]          vel_next;
  logic signed [19:0]               off_prod;
  logic signed [19:0]               off_adj;
  logic signed [9:0]                off;
  logic signed [11:0]               pulse_sum;
  logic signed [11:0]               step;
  logic signed [17:0]               est_sum;
  logic [ANGLE_W-1:0]               est_next;
  logic [ANGLE_W-1:0]               tgt_next;

  spc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd.valid),
    .cmd_op   (cmd.operation),
    .out_busy (out_busy),
    .ctl      (ctl)
  );

  spc_mul u_mul (
    .clk(clk),
    .a  (mul_a),
    .b  (mul_b),
    .p  (mul_p)
  );

  assign out_busy  = res_valid && !res.ready;
  assign cmd.ready = ctl.in_ready;
  assign cfg.ready = 1'b1;

  assign res.valid           = res_valid;
  assign res.pulse_width     = res_pulse;
  assign res.velocity        = res_vel;
  assign res.estimated_angle = res_est;

  assign err = $signed({1'b0, tgt_pos}) - $signed({1'b0, est_pos});

  always_comb begin
    case (ctl.mul_sel)
      SEL_GAIN: begin
        mul_a = $signed({1'b0, kp});
        mul_b = err;
      end
      SEL_PULSE: begin
        mul_a = MUL_A_W'(vel);
        mul_b = PULSE_SPAN;
      end
      SEL_STEP: begin
        mul_a = MUL_A_W'(vel);
        mul_b = STEP_MUL;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // velocity: floor shift then saturate
  always_comb begin
    vel_raw = mul_p[MUL_P_W-1:VEL_SH];
    if (vel_raw > (MUL_P_W-VEL_SH)'(VEL_MAX)) begin
      vel_next = VEL_MAX;
    end else if (vel_raw < (MUL_P_W-VEL_SH)'(VEL_MIN)) begin
      vel_next = VEL_MIN;
    end else begin
      vel_next = vel_raw[VEL_W-1:0];
    end
  end

  // pulse offset truncates toward zero
  always_comb begin
    off_prod  = mul_p[19:0];
    off_adj   = off_prod + (off_prod[19] ? 20'sd1023 : 20'sd0);
    off       = off_adj[19:10];
    pulse_sum = $signed({1'b0, PULSE_MID}) + 12'(off);
  end

  always_comb begin
    step    = mul_p[13:2];
    est_sum = $signed({2'b00, est_pos}) + 18'(step);
    if (est_sum < 18'sd0) begin
      est_next = '0;
    end else if (est_sum > $signed({2'b00, ANGLE_MAX})) begin
      est_next = ANGLE_MAX;
    end else begin
      est_next = est_sum[ANGLE_W-1:0];
    end
  end

  always_comb begin
    if (cmd.goal_angle[TA_W-1]) begin
      tgt_next = '0;
    end else if (cmd.goal_angle[ANGLE_W-1:0] > ANGLE_MAX) begin
      tgt_next = ANGLE_MAX;
    end else begin
      tgt_next = cmd.goal_angle[ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kp        <= KP_RESET;
      tgt_pos   <= '0;
      est_pos   <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        kp <= cfg.kp;
      end
      if (ctl.set_tgt) begin
        tgt_pos <= tgt_next;
      end
      if (ctl.load_out) begin
        est_pos   <= est_next;
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_vel) begin
      vel <= vel_next;
    end
    if (ctl.load_pulse) begin
      pulse <= pulse_sum[PULSE_W-1:0];
    end
    if (ctl.load_out) begin
      res_pulse <= pulse;
      res_vel   <= vel;
      res_est   <= est_next;
    end
  end

  `SPC_ASSERT_ALWAYS(a_est_range, est_pos <= ANGLE_MAX)
  `SPC_ASSERT_ALWAYS(a_tgt_range, tgt_pos <= ANGLE_MAX)
  `SPC_ASSERT_IMPLY(a_vel_range, res_valid, (res_vel <= VEL_MAX) && (res_vel >= VEL_MIN))
  `SPC_ASSERT_IMPLY(a_stop_pulse, res_valid && (res_vel == '0), res_pulse == PULSE_MID)

endmodule
